// ----- design/pli_pkg.sv -----
// ----------------------------------------------------------------------------
// Piecewise linear interpolator package
// Shared widths, codes and the command and status bundles that pass between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package pli_pkg;

   localparam int TIME_W    = 32;
   localparam int COORD_W   = 32;
   localparam int CFG_W     = 11;
   localparam int INDEX_W   = 10;
   localparam int FRAC_BITS = 16;
   localparam int NUM_AXES  = 3;
   localparam int AXIS_W    = 2;
   localparam int STEP_W    = $clog2(FRAC_BITS);

   localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(FRAC_BITS - 1);
   localparam logic [AXIS_W-1:0] AXIS_LAST = AXIS_W'(NUM_AXES - 1);

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef enum logic [1:0] {
      RS_INTERP = 2'd0,
      RS_FIRST  = 2'd1,
      RS_LAST   = 2'd2,
      RS_EMPTY  = 2'd3
   } range_status_type;

   typedef enum logic [1:0] {
      RD_ZERO,
      RD_ONE,
      RD_LAST,
      RD_STEP
   } rd_sel_type;

   typedef enum logic [1:0] {
      RES_KEEP,
      RES_ZERO,
      RES_RD,
      RES_AXIS
   } res_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIRST,
      ST_LAST,
      ST_SCAN,
      ST_DIV,
      ST_MUL,
      ST_ACC,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              load;
      logic              start;
      logic              rd_en;
      rd_sel_type        rd_sel;
      logic              save_prev;
      logic              save_cur;
      logic              div_init;
      logic              div_step;
      logic              mul;
      logic [AXIS_W-1:0] axis;
      res_op_type        res_op;
      range_status_type  status;
      logic              out_load;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic t_le;
      logic t_ge;
      logic at_last;
   } dp_status_type;

endpackage

// ----- design/pli_dp.sv -----
// ----------------------------------------------------------------------------
// Piecewise linear interpolator datapath
// Breakpoint memories, scan index, bit-serial fraction divider, shared
// multiplier for the three axes, and the result and output registers.
// ----------------------------------------------------------------------------
module pli_dp #(
   parameter int MAX_POINTS = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  pli_pkg::cmd_type                    cmd,
   output pli_pkg::dp_status_type              status,
   input  logic                                csr_we,
   input  logic [pli_pkg::CFG_W-1:0]           csr_entries_in_use,
   input  logic [pli_pkg::INDEX_W-1:0]         req_entry_index,
   input  logic [pli_pkg::TIME_W-1:0]          req_time_value,
   input  logic signed [pli_pkg::COORD_W-1:0]  req_point_x,
   input  logic signed [pli_pkg::COORD_W-1:0]  req_point_y,
   input  logic signed [pli_pkg::COORD_W-1:0]  req_point_z,
   output logic signed [pli_pkg::COORD_W-1:0]  rsp_result_x,
   output logic signed [pli_pkg::COORD_W-1:0]  rsp_result_y,
   output logic signed [pli_pkg::COORD_W-1:0]  rsp_result_z,
   output logic [1:0]                          rsp_range_status
);
   import pli_pkg::*;

   localparam int AW     = $clog2(MAX_POINTS);
   localparam int CW     = $clog2(MAX_POINTS + 1);
   localparam int PROD_W = COORD_W + FRAC_BITS + 2;

   logic [CFG_W-1:0]           entries_ff, entries_in;
   logic [CW-1:0]              n_w, last_w;
   logic [AW-1:0]              last_idx;
   logic [31:0]                wr_idx32;
   logic                       wr_ok;
   logic [AW-1:0]              wr_addr, rd_addr;
   logic [AW-1:0]              idx_ff;

   logic [TIME_W-1:0]          time_store [MAX_POINTS];
   logic [3*COORD_W-1:0]       point_store [MAX_POINTS];
   logic [TIME_W-1:0]          rd_time_ff;
   logic [3*COORD_W-1:0]       rd_point_ff;

   logic [TIME_W-1:0]          t_ff, t0_ff;
   logic [COORD_W-1:0]         p0_ff [NUM_AXES];
   logic [COORD_W-1:0]         p1_ff [NUM_AXES];

   logic [TIME_W-1:0]          rem_ff, den_ff;
   logic [FRAC_BITS-1:0]       quo_ff;
   logic [TIME_W:0]            rem_sh, rem_sub;
   logic                       rem_ge;

   logic [COORD_W-1:0]         v0_w, v1_w;
   logic signed [COORD_W:0]    delta_w;
   logic signed [PROD_W-1:0]   prod_w, prod_ff, shifted_w;
   logic [COORD_W-1:0]         acc_w;

   logic [COORD_W-1:0]         res_ff [NUM_AXES];
   range_status_type           res_status_ff;
   logic signed [COORD_W-1:0]  out_x_ff, out_y_ff, out_z_ff;
   range_status_type           out_status_ff;

   // Configuration register and the clamped entry count.
   assign entries_in = csr_we ? csr_entries_in_use : entries_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= '0;
      end else begin
         entries_ff <= entries_in;
      end
   end

   always_comb begin
      n_w      = (32'(entries_ff) > 32'(MAX_POINTS)) ? CW'(MAX_POINTS) : CW'(entries_ff);
      last_w   = n_w - CW'(1);
      last_idx = last_w[AW-1:0];
   end

   // Loads whose slot lies beyond the table are dropped.
   always_comb begin
      wr_idx32 = 32'(req_entry_index);
      wr_ok    = cmd.load && (wr_idx32 < 32'(MAX_POINTS));
      wr_addr  = wr_idx32[AW-1:0];
   end

   always_comb begin
      unique case (cmd.rd_sel)
         RD_ZERO: rd_addr = '0;
         RD_ONE:  rd_addr = AW'(1);
         RD_LAST: rd_addr = last_idx;
         RD_STEP: rd_addr = idx_ff + AW'(1);
         default: rd_addr = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_ok) begin
         time_store[wr_addr]  <= req_time_value;
         point_store[wr_addr] <= {req_point_z, req_point_y, req_point_x};
      end
      if (cmd.rd_en) begin
         rd_time_ff  <= time_store[rd_addr];
         rd_point_ff <= point_store[rd_addr];
      end
   end

   // The index always names the slot whose data sits in the read register.
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         idx_ff <= rd_addr;
      end
      if (cmd.start) begin
         t_ff <= req_time_value;
      end
      if (cmd.save_prev) begin
         t0_ff <= rd_time_ff;
         for (int k = 0; k < NUM_AXES; k++) begin
            p0_ff[k] <= rd_point_ff[k*COORD_W +: COORD_W];
         end
      end
      if (cmd.save_cur) begin
         for (int k = 0; k < NUM_AXES; k++) begin
            p1_ff[k] <= rd_point_ff[k*COORD_W +: COORD_W];
         end
      end
   end

   // Restoring division, one quotient bit a cycle. The remainder starts below
   // the divisor, so the quotient fits in the fraction bits.
   always_comb begin
      rem_sh  = {rem_ff, 1'b0};
      rem_ge  = rem_sh >= {1'b0, den_ff};
      rem_sub = rem_sh - {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         rem_ff <= t_ff - t0_ff;
         den_ff <= rd_time_ff - t0_ff;
      end else if (cmd.div_step) begin
         rem_ff <= rem_ge ? rem_sub[TIME_W-1:0] : rem_sh[TIME_W-1:0];
         quo_ff <= {quo_ff[FRAC_BITS-2:0], rem_ge};
      end
   end

   // One axis at a time through a shared multiplier; the arithmetic shift
   // gives the floor toward minus infinity.
   always_comb begin
      v0_w      = p0_ff[cmd.axis];
      v1_w      = p1_ff[cmd.axis];
      delta_w   = $signed({v1_w[COORD_W-1], v1_w}) - $signed({v0_w[COORD_W-1], v0_w});
      prod_w    = PROD_W'(delta_w) * PROD_W'($signed({1'b0, quo_ff}));
      shifted_w = prod_ff >>> FRAC_BITS;
      acc_w     = v0_w + shifted_w[COORD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_ff <= prod_w;
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.res_op)
         RES_ZERO: begin
            for (int k = 0; k < NUM_AXES; k++) begin
               res_ff[k] <= '0;
            end
         end
         RES_RD: begin
            for (int k = 0; k < NUM_AXES; k++) begin
               res_ff[k] <= rd_point_ff[k*COORD_W +: COORD_W];
            end
         end
         RES_AXIS: begin
            res_ff[cmd.axis] <= acc_w;
         end
         default: begin
         end
      endcase
      if (cmd.res_op != RES_KEEP) begin
         res_status_ff <= cmd.status;
      end
      if (cmd.out_load) begin
         out_x_ff      <= res_ff[0];
         out_y_ff      <= res_ff[1];
         out_z_ff      <= res_ff[2];
         out_status_ff <= res_status_ff;
      end
   end

   always_comb begin
      status.empty   = (n_w == '0);
      status.t_le    = (t_ff <= rd_time_ff);
      status.t_ge    = (t_ff >= rd_time_ff);
      status.at_last = (idx_ff == last_idx);
   end

   assign rsp_result_x     = out_x_ff;
   assign rsp_result_y     = out_y_ff;
   assign rsp_result_z     = out_z_ff;
   assign rsp_range_status = out_status_ff;

endmodule

// ----- design/pli_ctrl.sv -----
// ----------------------------------------------------------------------------
// Piecewise linear interpolator controller
// Sequences each query through the clamp checks, the breakpoint scan, the
// fraction division and the per-axis blend, and owns the handshakes.
// ----------------------------------------------------------------------------
module pli_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_opcode,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  pli_pkg::dp_status_type status,
   output pli_pkg::cmd_type       cmd
);
   import pli_pkg::*;

   state_type          state_ff, state_in;
   logic [STEP_W-1:0]  cnt_ff, cnt_in;
   logic [AXIS_W-1:0]  axis_ff, axis_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         axis_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      axis_in      = axis_ff;
      cmd          = '0;
      cmd.axis     = axis_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_opcode == OP_LOAD) begin
                  cmd.load = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  if (status.empty) begin
                     cmd.res_op = RES_ZERO;
                     cmd.status = RS_EMPTY;
                     state_in   = ST_DONE;
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_ZERO;
                     state_in   = ST_FIRST;
                  end
               end
            end
         end
         ST_FIRST: begin
            cmd.save_prev = 1'b1;
            if (status.t_le) begin
               cmd.res_op = RES_RD;
               cmd.status = RS_FIRST;
               state_in   = ST_DONE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_LAST;
               state_in   = ST_LAST;
            end
         end
         ST_LAST: begin
            if (status.t_ge) begin
               cmd.res_op = RES_RD;
               cmd.status = RS_LAST;
               state_in   = ST_DONE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_ONE;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!status.t_ge) begin
               // First slot later than the query: bracket found.
               cmd.save_cur = 1'b1;
               cmd.div_init = 1'b1;
               cnt_in       = '0;
               state_in     = ST_DIV;
            end else if (status.at_last) begin
               cmd.res_op = RES_RD;
               cmd.status = RS_LAST;
               state_in   = ST_DONE;
            end else begin
               cmd.save_prev = 1'b1;
               cmd.rd_en     = 1'b1;
               cmd.rd_sel    = RD_STEP;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + STEP_W'(1);
            if (cnt_ff == DIV_LAST) begin
               axis_in  = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.res_op = RES_AXIS;
            cmd.status = RS_INTERP;
            if (axis_ff == AXIS_LAST) begin
               state_in = ST_DONE;
            end else begin
               axis_in  = axis_ff + AXIS_W'(1);
               state_in = ST_MUL;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The output register is only refilled once its word has gone.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("output word overwritten while pending");

   // A query closes the input channel until it is finished.
   a_query_blocks: assert property (@(posedge clock) disable iff (reset)
      (accept && req_opcode == OP_QUERY) |=> !req_ready)
      else $error("input still open after a query");

   // The multiplier is only reached from the divider or from the previous axis.
   a_mul_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> ($past(state_ff) == ST_DIV || $past(state_ff) == ST_ACC))
      else $error("blend started without a finished fraction");

   a_axis_range: assert property (@(posedge clock) disable iff (reset)
      axis_ff <= AXIS_LAST)
      else $error("axis counter out of range");

endmodule

// ----- design/piecewise_linear_interpolator.sv -----
// A load is written in the cycle it is taken; an empty-table query goes straight to
//   the output step, a clamped one once the first-slot or last-slot check settles it.
// An interpolated query scans with one memory read per slot up to the slot that closes it,
//   then takes 16 divider steps and a multiply and an accumulate step per axis.
// Throughput: loads one per cycle while idle; queries one at a time, the next taken once the previous
//   word sits in the output register. Reset clears control and the count, not the memories.
// ----------------------------------------------------------------------------
// Piecewise linear interpolator
// Holds a table of timed breakpoints and returns the x, y, z point
// interpolated or clamped at a query time.
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator #(
   parameter int MAX_POINTS = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [pli_pkg::CFG_W-1:0]           csr_entries_in_use,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_opcode,
   input  logic [pli_pkg::INDEX_W-1:0]         req_entry_index,
   input  logic [pli_pkg::TIME_W-1:0]          req_time_value,
   input  logic signed [pli_pkg::COORD_W-1:0]  req_point_x,
   input  logic signed [pli_pkg::COORD_W-1:0]  req_point_y,
   input  logic signed [pli_pkg::COORD_W-1:0]  req_point_z,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [pli_pkg::COORD_W-1:0]  rsp_result_x,
   output logic signed [pli_pkg::COORD_W-1:0]  rsp_result_y,
   output logic signed [pli_pkg::COORD_W-1:0]  rsp_result_z,
   output logic [1:0]                          rsp_range_status
);
   import pli_pkg::*;

   cmd_type       cmd;
   dp_status_type status;

   pli_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .status     (status),
      .cmd        (cmd)
   );

   pli_dp #(
      .MAX_POINTS (MAX_POINTS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_we             (csr_we),
      .csr_entries_in_use (csr_entries_in_use),
      .req_entry_index    (req_entry_index),
      .req_time_value     (req_time_value),
      .req_point_x        (req_point_x),
      .req_point_y        (req_point_y),
      .req_point_z        (req_point_z),
      .rsp_result_x       (rsp_result_x),
      .rsp_result_y       (rsp_result_y),
      .rsp_result_z       (rsp_result_z),
      .rsp_range_status   (rsp_range_status)
   );

endmodule
